// ===== rtl/core/aabb_collision_resolve_top_defines.svh =====
// Assertion macros shared by the collision resolver RTL.
`ifndef AABB_COLLISION_RESOLVE_TOP_DEFINES_SVH
`define AABB_COLLISION_RESOLVE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("collision resolver check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("collision resolver check failed");

`endif

// ===== rtl/core/acr_pkg.sv =====
// Types, widths and helper functions of the collision resolver.
package acr_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int EXTENT_WIDTH = COORD_WIDTH - 1;
    localparam int DEPTH_WIDTH  = COORD_WIDTH + 2;
    localparam int PUSH_WIDTH   = COORD_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [EXTENT_WIDTH-1:0] extent_t;
    typedef logic signed [DEPTH_WIDTH-1:0] depth_t;
    typedef logic signed [PUSH_WIDTH-1:0]  push_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Mode register values.
    localparam logic MODE_TOP_DOWN   = 1'b0;
    localparam logic MODE_PLATFORMER = 1'b1;

    typedef struct packed {
        coord_t  body_x;
        coord_t  body_y;
        extent_t body_w;
        extent_t body_h;
        coord_t  vel_x;
        coord_t  vel_y;
        coord_t  box_x;
        coord_t  box_y;
        extent_t box_w;
        extent_t box_h;
    } item_t;

    typedef struct packed {
        coord_t new_x;
        coord_t new_y;
        coord_t new_vel_x;
        coord_t new_vel_y;
        logic   hit;
        logic   landed;
    } result_t;

    // Clamp a pushed position, one bit wider than a coordinate, to the coordinate range.
    function automatic coord_t sat_push(input push_t p);
        coord_t r;
        if (p[PUSH_WIDTH-1] != p[PUSH_WIDTH-2])
        begin
            r = p[PUSH_WIDTH-1] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r = p[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // True when a depth is strictly positive.
    function automatic logic depth_pos(input depth_t d);
        return !d[DEPTH_WIDTH-1] && (d != '0);
    endfunction

endpackage

// ===== rtl/core/acr_item_if.sv =====
// Request channel carrying one moving box and one collider box.
interface acr_item_if;
    logic                  valid;
    logic                  ready;
    acr_pkg::coord_t       body_x;
    acr_pkg::coord_t       body_y;
    acr_pkg::extent_t      body_w;
    acr_pkg::extent_t      body_h;
    acr_pkg::coord_t       vel_x;
    acr_pkg::coord_t       vel_y;
    acr_pkg::coord_t       box_x;
    acr_pkg::coord_t       box_y;
    acr_pkg::extent_t      box_w;
    acr_pkg::extent_t      box_h;

    modport source (output valid, body_x, body_y, body_w, body_h, vel_x, vel_y,
                    box_x, box_y, box_w, box_h, input ready);
    modport sink   (input valid, body_x, body_y, body_w, body_h, vel_x, vel_y,
                    box_x, box_y, box_w, box_h, output ready);
endinterface

// ===== rtl/core/acr_result_if.sv =====
// Result channel carrying the resolved position, velocity and flags.
interface acr_result_if;
    logic             valid;
    logic             ready;
    acr_pkg::coord_t  new_x;
    acr_pkg::coord_t  new_y;
    acr_pkg::coord_t  new_vel_x;
    acr_pkg::coord_t  new_vel_y;
    logic             hit;
    logic             landed;

    modport source (output valid, new_x, new_y, new_vel_x, new_vel_y, hit, landed,
                    input ready);
    modport sink   (input valid, new_x, new_y, new_vel_x, new_vel_y, hit, landed,
                    output ready);
endinterface

// ===== rtl/core/acr_cfg_if.sv =====
// Configuration write channel carrying the mode register.
interface acr_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, mode, input ready);
    modport sink   (input valid, mode, output ready);
endinterface

// ===== rtl/core/aabb_collision_resolve_top.sv =====
// Top level of the axis-aligned box collision resolver.
//
//  Channel  Dir  Contents
//  -------  ---  ----------------------------------------------------------
//  item     in   moving box position, size, velocity and collider box
//  result   out  resolved position, velocity, hit and landed flags
//  cfg      in   mode register write (0 top-down, 1 platformer)
//
// One request enters per clock cycle while the result side keeps taking results.
// An accepted request is registered in the input register, and its result is
// registered in the result register. The path between the two registers is a
// set of adders and magnitude compares, so throughput is one per cycle unless
// the result side stalls. A stalled result holds the result register; the input
// register can still take one more request, and only when both are full does
// the input stall. Reset clears both valid flags and sets the mode to top-down.

`include "aabb_collision_resolve_top_defines.svh"

module aabb_collision_resolve_top (
    input  logic          clk,
    input  logic          rst_n,
    acr_item_if.sink      item,
    acr_result_if.source  result,
    acr_cfg_if.sink       cfg
);

    // Pipeline control and payload registers.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    acr_pkg::item_t    s1_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    acr_pkg::result_t  res_reg;
    acr_pkg::result_t  res_next;
    logic              mode_reg;

    logic              s1_load;
    logic              res_load;

    // Penetration depths and push candidates.
    acr_pkg::depth_t   dl;
    acr_pkg::depth_t   dr;
    acr_pkg::depth_t   db;
    acr_pkg::depth_t   dt;
    acr_pkg::depth_t   mx;
    acr_pkg::depth_t   my;
    logic              overlap;
    logic              plat;
    logic              vy_pos;
    logic              vy_neg;

    // Always ready; writes must come only while idle, which the block does not check.
    assign cfg.ready = 1'b1;

    // A held request loads the result register when it is empty or its result is taken.
    assign res_load   = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || res_load;
    assign s1_load    = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (res_load)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mode_reg      <= acr_pkg::MODE_TOP_DOWN;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                mode_reg <= cfg.mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg.body_x <= item.body_x;
            s1_reg.body_y <= item.body_y;
            s1_reg.body_w <= item.body_w;
            s1_reg.body_h <= item.body_h;
            s1_reg.vel_x  <= item.vel_x;
            s1_reg.vel_y  <= item.vel_y;
            s1_reg.box_x  <= item.box_x;
            s1_reg.box_y  <= item.box_y;
            s1_reg.box_w  <= item.box_w;
            s1_reg.box_h  <= item.box_h;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    // Depths toward each side. They are two bits wider than a coordinate so
    // that the sum of an edge and an extent minus another edge cannot wrap.
    assign dl = acr_pkg::depth_t'(s1_reg.body_x) + acr_pkg::depth_t'(s1_reg.body_w)
              - acr_pkg::depth_t'(s1_reg.box_x);
    assign dr = acr_pkg::depth_t'(s1_reg.box_x) + acr_pkg::depth_t'(s1_reg.box_w)
              - acr_pkg::depth_t'(s1_reg.body_x);
    assign db = acr_pkg::depth_t'(s1_reg.body_y) + acr_pkg::depth_t'(s1_reg.body_h)
              - acr_pkg::depth_t'(s1_reg.box_y);
    assign dt = acr_pkg::depth_t'(s1_reg.box_y) + acr_pkg::depth_t'(s1_reg.box_h)
              - acr_pkg::depth_t'(s1_reg.body_y);

    assign overlap = acr_pkg::depth_pos(dl) && acr_pkg::depth_pos(dr)
                  && acr_pkg::depth_pos(db) && acr_pkg::depth_pos(dt);

    assign mx = (dl < dr) ? dl : dr;
    assign my = (db < dt) ? db : dt;

    assign plat   = (mode_reg == acr_pkg::MODE_PLATFORMER);
    assign vy_pos = !s1_reg.vel_y[acr_pkg::COORD_WIDTH-1] && (s1_reg.vel_y != '0);
    assign vy_neg = s1_reg.vel_y[acr_pkg::COORD_WIDTH-1];

    // Pushing the body left by dl puts its right edge on the collider's left
    // edge, so the new x is box_x - body_w; the other pushes work the same way.
    always_comb
    begin
        res_next.new_x     = s1_reg.body_x;
        res_next.new_y     = s1_reg.body_y;
        res_next.new_vel_x = s1_reg.vel_x;
        res_next.new_vel_y = s1_reg.vel_y;
        res_next.hit       = overlap;
        res_next.landed    = 1'b0;

        if (overlap)
        begin
            if (mx < my)
            begin
                // Horizontal push; equal depths push right.
                if (dl < dr)
                begin
                    res_next.new_x = acr_pkg::sat_push(acr_pkg::push_t'(s1_reg.box_x)
                                   - acr_pkg::push_t'(s1_reg.body_w));
                end
                else
                begin
                    res_next.new_x = acr_pkg::sat_push(acr_pkg::push_t'(s1_reg.box_x)
                                   + acr_pkg::push_t'(s1_reg.box_w));
                end
                if (plat)
                begin
                    res_next.new_vel_x = '0;
                end
            end
            else if (db < dt)
            begin
                // Up onto the collider top; a falling platformer body lands.
                res_next.new_y = acr_pkg::sat_push(acr_pkg::push_t'(s1_reg.box_y)
                               - acr_pkg::push_t'(s1_reg.body_h));
                if (plat && vy_pos)
                begin
                    res_next.new_vel_y = '0;
                    res_next.landed    = 1'b1;
                end
            end
            else
            begin
                // Down through the collider bottom; this also takes the tie.
                res_next.new_y = acr_pkg::sat_push(acr_pkg::push_t'(s1_reg.box_y)
                               + acr_pkg::push_t'(s1_reg.box_h));
                if (plat && vy_neg)
                begin
                    res_next.new_vel_y = '0;
                end
            end
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.new_x     = res_reg.new_x;
    assign result.new_y     = res_reg.new_y;
    assign result.new_vel_x = res_reg.new_vel_x;
    assign result.new_vel_y = res_reg.new_vel_y;
    assign result.hit       = res_reg.hit;
    assign result.landed    = res_reg.landed;

    // A landing needs a hit, platformer mode and a cleared vertical velocity.
    `ACR_ASSERT_SAME(a_landed_hit, clk, rst_n, res_valid_reg && res_reg.landed,
        res_reg.hit && (res_reg.new_vel_y == '0))
    `ACR_ASSERT_SAME(a_landed_mode, clk, rst_n, res_valid_reg && res_reg.landed,
        mode_reg == acr_pkg::MODE_PLATFORMER)
    // An accepted request always occupies the input register next cycle.
    `ACR_ASSERT_NEXT(a_s1_fill, clk, rst_n, s1_load, s1_valid_reg)
    // A request leaving the input register shows up as a valid result.
    `ACR_ASSERT_NEXT(a_res_fill, clk, rst_n, res_load, res_valid_reg)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the box collision resolver top level.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;
    localparam int EMAX = 8388607;

    // Scoreboard: it predicts each resolution when a request is accepted and
    // compares every result with the oldest prediction still waiting.
    class resolution_scoreboard;
        logic              mode = acr_pkg::MODE_TOP_DOWN;
        acr_pkg::result_t  expected_resolutions[$];
        int unsigned       requests = 0;
        int unsigned       checked = 0;
        int unsigned       mismatches = 0;
        int unsigned       hits = 0;
        int unsigned       landings = 0;

        function void set_mode(input logic m);
            mode = m;
        endfunction

        function int unsigned outstanding();
            return expected_resolutions.size();
        endfunction

        function acr_pkg::coord_t clamp_coord(input longint v);
            if (v > longint'(acr_pkg::COORD_MAX))
            begin
                return acr_pkg::COORD_MAX;
            end
            if (v < longint'(acr_pkg::COORD_MIN))
            begin
                return acr_pkg::COORD_MIN;
            end
            return acr_pkg::coord_t'(v);
        endfunction

        // Resolve one body against one collider exactly as the block should.
        function acr_pkg::result_t resolve_expected(input acr_pkg::item_t it);
            longint            bx, by, bw, bh, cx, cy, cw, ch;
            longint            dl, dr, db, dt, mx, my;
            acr_pkg::result_t  r;
            bx = it.body_x;
            by = it.body_y;
            bw = it.body_w;
            bh = it.body_h;
            cx = it.box_x;
            cy = it.box_y;
            cw = it.box_w;
            ch = it.box_h;
            dl = bx + bw - cx;
            dr = cx + cw - bx;
            db = by + bh - cy;
            dt = cy + ch - by;
            r.new_x     = it.body_x;
            r.new_y     = it.body_y;
            r.new_vel_x = it.vel_x;
            r.new_vel_y = it.vel_y;
            r.hit       = 1'b0;
            r.landed    = 1'b0;
            if (dl > 0 && dr > 0 && db > 0 && dt > 0)
            begin
                r.hit = 1'b1;
                mx = (dl < dr) ? dl : dr;
                my = (db < dt) ? db : dt;
                if (mx < my)
                begin
                    r.new_x = (dl < dr) ? clamp_coord(bx - dl) : clamp_coord(bx + dr);
                    if (mode == acr_pkg::MODE_PLATFORMER)
                    begin
                        r.new_vel_x = '0;
                    end
                end
                else if (db < dt)
                begin
                    r.new_y = clamp_coord(by - db);
                    if (mode == acr_pkg::MODE_PLATFORMER && it.vel_y > 0)
                    begin
                        r.new_vel_y = '0;
                        r.landed    = 1'b1;
                    end
                end
                else
                begin
                    r.new_y = clamp_coord(by + dt);
                    if (mode == acr_pkg::MODE_PLATFORMER && it.vel_y < 0)
                    begin
                        r.new_vel_y = '0;
                    end
                end
            end
            return r;
        endfunction

        function void note_request(input acr_pkg::item_t it);
            acr_pkg::result_t r;
            r = resolve_expected(it);
            requests++;
            hits += r.hit;
            landings += r.landed;
            expected_resolutions = {expected_resolutions, r};
        endfunction

        function void check_result(input acr_pkg::result_t got);
            acr_pkg::result_t want;
            if (expected_resolutions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result with nothing expected: x=%0d y=%0d vx=%0d vy=%0d",
                             got.new_x, got.new_y, got.new_vel_x, got.new_vel_y);
                end
                return;
            end
            want = expected_resolutions.pop_front();
            checked++;
            if (got.new_x !== want.new_x || got.new_y !== want.new_y ||
                got.new_vel_x !== want.new_vel_x || got.new_vel_y !== want.new_vel_y ||
                got.hit !== want.hit || got.landed !== want.landed)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"ERROR: result %0d expected x=%0d y=%0d vx=%0d vy=%0d ",
                              "hit=%0b landed=%0b"},
                             checked, want.new_x, want.new_y, want.new_vel_x,
                             want.new_vel_y, want.hit, want.landed);
                    $display({"       got           x=%0d y=%0d vx=%0d vy=%0d ",
                              "hit=%0b landed=%0b"},
                             got.new_x, got.new_y, got.new_vel_x, got.new_vel_y,
                             got.hit, got.landed);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    acr_item_if   item_bus();
    acr_result_if result_bus();
    acr_cfg_if    cfg_bus();

    aabb_collision_resolve_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    resolution_scoreboard sb = new;

    // When set, neither the request side nor the result side idles any more.
    bit              quiet_phase = 1'b0;
    int unsigned     mode_writes = 0;
    acr_pkg::item_t  directed_cases[$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Every input of the block starts at a known value before reset releases.
    initial
    begin
        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.body_x  = '0;
        item_bus.body_y  = '0;
        item_bus.body_w  = '0;
        item_bus.body_h  = '0;
        item_bus.vel_x   = '0;
        item_bus.vel_y   = '0;
        item_bus.box_x   = '0;
        item_bus.box_y   = '0;
        item_bus.box_w   = '0;
        item_bus.box_h   = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.mode     = acr_pkg::MODE_TOP_DOWN;
        result_bus.ready = 1'b0;
    end

    // The result side takes results in bursts and stalls at random, so back
    // pressure lands on every stage of the pipeline.
    initial
    begin
        int unsigned n;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_phase && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 10);
                @(negedge clk);
                result_bus.ready = 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 20);
                @(negedge clk);
                result_bus.ready = 1'b1;
            end
            repeat (n - 1) @(negedge clk);
        end
    end

    // Results are sampled at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        acr_pkg::result_t got;
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            got.new_x     = result_bus.new_x;
            got.new_y     = result_bus.new_y;
            got.new_vel_x = result_bus.new_vel_x;
            got.new_vel_y = result_bus.new_vel_y;
            got.hit       = result_bus.hit;
            got.landed    = result_bus.landed;
            sb.check_result(got);
        end
    end

    // Present one request at the falling edge and hold it until the block
    // takes it. The valid stays high so back-to-back requests need no gap.
    task automatic send_request(input acr_pkg::item_t it);
        @(negedge clk);
        item_bus.valid  = 1'b1;
        item_bus.body_x = it.body_x;
        item_bus.body_y = it.body_y;
        item_bus.body_w = it.body_w;
        item_bus.body_h = it.body_h;
        item_bus.vel_x  = it.vel_x;
        item_bus.vel_y  = it.vel_y;
        item_bus.box_x  = it.box_x;
        item_bus.box_y  = it.box_y;
        item_bus.box_w  = it.box_w;
        item_bus.box_h  = it.box_h;
        do @(posedge clk); while (item_bus.ready !== 1'b1);
        sb.note_request(it);
    endtask

    // Now and then, outside the quiet phase, the request side goes quiet.
    task automatic request_gap();
        int unsigned n;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 10);
            @(negedge clk);
            item_bus.valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drop the request valid and wait until every predicted result has come.
    task automatic drain();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // The mode only changes while the block holds no request at all. Every
    // request yields exactly one result, so an empty scoreboard means idle.
    task automatic write_mode(input logic m);
        drain();
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.mode  = m;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        sb.set_mode(m);
        mode_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic acr_pkg::coord_t fit_coord(input int v);
        if (v > CMAX)
        begin
            return acr_pkg::COORD_MAX;
        end
        if (v < CMIN)
        begin
            return acr_pkg::COORD_MIN;
        end
        return acr_pkg::coord_t'(v);
    endfunction

    function automatic void add_case(input int bx, input int by, input int bw, input int bh,
                                     input int vx, input int vy, input int cx, input int cy,
                                     input int cw, input int ch);
        acr_pkg::item_t it;
        it.body_x = acr_pkg::coord_t'(bx);
        it.body_y = acr_pkg::coord_t'(by);
        it.body_w = acr_pkg::extent_t'(bw);
        it.body_h = acr_pkg::extent_t'(bh);
        it.vel_x  = acr_pkg::coord_t'(vx);
        it.vel_y  = acr_pkg::coord_t'(vy);
        it.box_x  = acr_pkg::coord_t'(cx);
        it.box_y  = acr_pkg::coord_t'(cy);
        it.box_w  = acr_pkg::extent_t'(cw);
        it.box_h  = acr_pkg::extent_t'(ch);
        directed_cases = {directed_cases, it};
    endfunction

    function automatic acr_pkg::coord_t random_velocity();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return acr_pkg::coord_t'(int'($urandom_range(1, 2000)));
            2:       return acr_pkg::coord_t'(-int'($urandom_range(1, 2000)));
            default: return acr_pkg::coord_t'($urandom);
        endcase
    endfunction

    // Of every 100 random requests, 45 are a body that really overlaps the collider,
    // with random depths. The rest are touching pairs, exact ties, pushes near the
    // edge of the coordinate range, and raw noise on every bit.
    function automatic acr_pkg::item_t make_request();
        acr_pkg::item_t  it;
        logic [255:0]    noise;
        int unsigned     kind;
        int              bx, by, bw, bh, cx, cy, cw, ch, j;
        kind = $urandom_range(0, 99);
        if (kind < 13)
        begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom};
            it = acr_pkg::item_t'(noise[$bits(acr_pkg::item_t)-1:0]);
            return it;
        end
        bw = $urandom_range(1, 4096);
        bh = $urandom_range(1, 4096);
        cw = $urandom_range(1, 4096);
        ch = $urandom_range(1, 4096);
        cx = int'($urandom_range(0, 2097152)) - 1048576;
        cy = int'($urandom_range(0, 2097152)) - 1048576;
        bx = cx - bw + 1 + int'($urandom_range(0, bw + cw - 2));
        by = cy - bh + 1 + int'($urandom_range(0, bh + ch - 2));
        if (kind < 27)
        begin
            // Edges that only touch on one side never count as a hit.
            case ($urandom_range(0, 3))
                0:       bx = cx + cw;
                1:       bx = cx - bw;
                2:       by = cy + ch;
                default: by = cy - bh;
            endcase
        end
        else if (kind < 42)
        begin
            // Equal left and right depths, and often equal x and y depths.
            j  = $urandom_range(0, 1000);
            cw = bw + 2 * j;
            bx = cx + j;
            if ($urandom_range(0, 1) == 1)
            begin
                bh = bw;
                ch = cw;
                by = cy + j;
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                j  = $urandom_range(0, 1000);
                ch = bh + 2 * j;
                by = cy + j;
            end
        end
        else if (kind < 55)
        begin
            // A push along one axis right at the top or bottom of the range.
            if ($urandom_range(0, 1) == 1)
            begin
                cx = ($urandom_range(0, 1) == 1) ? CMAX - int'($urandom_range(0, 3000))
                                                 : CMIN + int'($urandom_range(0, 3000));
                bx = cx - bw + 1 + int'($urandom_range(0, bw + cw - 2));
                bh = $urandom_range(20000, 60000);
                ch = bh;
                by = cy;
            end
            else
            begin
                cy = ($urandom_range(0, 1) == 1) ? CMAX - int'($urandom_range(0, 3000))
                                                 : CMIN + int'($urandom_range(0, 3000));
                by = cy - bh + 1 + int'($urandom_range(0, bh + ch - 2));
                bw = $urandom_range(20000, 60000);
                cw = bw;
                bx = cx;
            end
        end
        it.body_x = fit_coord(bx);
        it.body_y = fit_coord(by);
        it.body_w = acr_pkg::extent_t'(bw);
        it.body_h = acr_pkg::extent_t'(bh);
        it.box_x  = fit_coord(cx);
        it.box_y  = fit_coord(cy);
        it.box_w  = acr_pkg::extent_t'(cw);
        it.box_h  = acr_pkg::extent_t'(ch);
        it.vel_x  = random_velocity();
        it.vel_y  = random_velocity();
        return it;
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count)
        begin
            request_gap();
            send_request(make_request());
        end
    endtask

    // Main sequence: reset, a directed pass in platformer mode, then random
    // phases that alternate the mode. The last phase runs without idling.
    initial
    begin
        // Touching edges, then two boxes far apart with extreme velocities.
        add_case(0, 0, 256, 256, 100, 100, 256, 0, 256, 256);
        add_case(CMAX, CMAX, 0, 0, CMAX, CMIN, CMIN, CMIN, EMAX, EMAX);
        // Push left, push right, and a left/right tie that pushes right.
        add_case(0, 0, 512, 1024, 300, -20, 400, 0, 512, 1024);
        add_case(400, 0, 512, 1024, -300, 20, 0, 0, 512, 1024);
        add_case(0, 0, 512, 2048, 77, 5, 0, 0, 512, 2048);
        // Push up while falling (a landing) and while rising.
        add_case(0, 0, 1024, 512, 0, 200, 0, 400, 1024, 512);
        add_case(0, 0, 1024, 512, 0, -200, 0, 400, 1024, 512);
        // Push down while rising (velocity cleared) and while falling.
        add_case(0, 400, 1024, 512, 0, -200, 0, 0, 1024, 512);
        add_case(0, 400, 1024, 512, 0, 200, 0, 0, 1024, 512);
        // A tie between the axes goes vertical; an up/down tie goes down.
        add_case(0, 0, 512, 512, 10, 0, 200, 200, 512, 512);
        add_case(0, 0, 2048, 512, 10, -1, 0, 0, 2048, 512);
        // Pushes that saturate at both ends of both axes.
        add_case(8388600, 0, 200, 1000, 5, 5, CMAX, 0, 100, 1000);
        add_case(-8388600, 0, 200, 1000, -5, 5, CMIN, 0, 1000, 1000);
        add_case(0, 8388605, 1000, 100, 3, -5, 0, 8388600, 1000, 100);
        add_case(0, -8388600, 1000, 200, 3, 7, 0, CMIN, 1000, 1000);
        // Extreme positions with the largest sizes.
        add_case(CMIN, CMIN, EMAX, EMAX, CMIN, CMIN, CMIN, CMIN, EMAX, EMAX);
        add_case(CMAX, CMAX, EMAX, EMAX, CMAX, CMAX, CMAX, CMAX, EMAX, EMAX);
        // Zero-size body, zero-size collider, and both empty at one spot.
        add_case(100, 100, 0, 0, 4, 9, 0, 0, 1000, 1000);
        add_case(0, 0, 1000, 1000, -4, -9, 100, 100, 0, 0);
        add_case(0, 0, 0, 0, 1, 1, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mode(acr_pkg::MODE_PLATFORMER);
        foreach (directed_cases[i])
        begin
            send_request(directed_cases[i]);
        end

        write_mode(acr_pkg::MODE_TOP_DOWN);
        run_random(225);
        write_mode(acr_pkg::MODE_PLATFORMER);
        run_random(225);
        write_mode(acr_pkg::MODE_TOP_DOWN);
        run_random(225);
        write_mode(acr_pkg::MODE_PLATFORMER);
        quiet_phase = 1'b1;
        run_random(225);

        // Everything is sent; collect the tail and allow for the pipeline.
        drain();
        repeat (4) @(posedge clk);

        $display("Resolved %0d requests (%0d hits, %0d landings) across %0d mode writes.",
                 sb.requests, sb.hits, sb.landings, mode_writes);
        $display("Checked %0d results: %0d mismatches, %0d still expected.",
                 sb.checked, sb.mismatches, sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("aabb_collision_resolve_top regression: pass");
        end
        else
        begin
            $display("aabb_collision_resolve_top regression: fail");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #5000000;
        $display("Timed out with %0d results still expected.", sb.outstanding());
        $display("aabb_collision_resolve_top regression: fail");
        $finish;
    end

endmodule
